@@ src/bmhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// bmhpq_pkg
// Shared types, constants and the ranking function of the heap queue.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

  localparam int CAPACITY = 128;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CIDX_W   = ADDR_W + 2;

  localparam logic       CMD_INSERT  = 1'b0;
  localparam logic       CMD_EXTRACT = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [15:0] sev;
    logic [31:0] arr;
    logic [15:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    RD_PARENT = 3'd0,
    RD_ROOT   = 3'd1,
    RD_LAST   = 3'd2,
    RD_LEFT   = 3'd3,
    RD_RIGHT  = 3'd4
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cap_root;
    logic    cap_cur;
    logic    cap_left;
    logic    pos_zero;
    logic    wr_cur;
    logic    up_eval;
    logic    down_eval;
    logic    fin;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_root;
    logic one_left;
    logic l_out;
    logic up_go;
    logic down_go;
  } stat_t;

  function automatic logic ranks_above(entry_t a, entry_t b);
    logic res;
    if (a.sev != b.sev) begin
      res = (a.sev > b.sev);
    end else begin
      res = (a.arr < b.arr);
    end
    return res;
  endfunction

  function automatic logic [7:0] count_low8(logic [CNT_W-1:0] c);
    logic [CNT_W+7:0] tmp;
    tmp = {8'd0, c};
    return tmp[7:0];
  endfunction

endpackage

@@ src/bmhpq_ram.sv @@
// ----------------------------------------------------------------------------
// bmhpq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bmhpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/bmhpq_datapath.sv @@
// ----------------------------------------------------------------------------
// bmhpq_datapath
// Heap store, moving entry, position and count registers, and result registers.
// ----------------------------------------------------------------------------
module bmhpq_datapath
  import bmhpq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        command,
  input  logic [15:0] severity,
  input  logic [31:0] arrival_stamp,
  input  logic [15:0] entry_tag,
  output logic [1:0]  status,
  output logic [15:0] out_severity,
  output logic [31:0] out_arrival,
  output logic [15:0] out_tag,
  output logic [7:0]  entry_count
);

  logic [ADDR_W-1:0] pos;
  logic [CNT_W-1:0]  held_count;
  entry_t            cur;
  entry_t            lreg;
  entry_t            res;
  logic [1:0]        res_status;

  logic              wr_en;
  entry_t            wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ENTRY_W-1:0] rd_raw;
  entry_t            rd_data;

  logic [CIDX_W-1:0] lidx;
  logic [CIDX_W-1:0] ridx;
  logic [CIDX_W-1:0] n_ext;
  logic [ADDR_W-1:0] parent;
  logic              full;
  logic              empty;
  logic              r_in;
  logic              left_better;
  logic              right_better;
  entry_t            best_l;
  entry_t            child;
  logic [CIDX_W-1:0] child_idx;

  assign rd_data = entry_t'(rd_raw);
  assign lidx    = {1'b0, pos, 1'b1};
  assign ridx    = lidx + CIDX_W'(1);
  assign n_ext   = CIDX_W'(held_count);
  assign parent  = ADDR_W'((pos - ADDR_W'(1)) >> 1);
  assign full    = (held_count >= CNT_W'(CAPACITY));
  assign empty   = (held_count == '0);
  assign r_in    = (ridx < n_ext);

  assign left_better  = ranks_above(lreg, cur);
  assign best_l       = left_better ? lreg : cur;
  assign right_better = r_in && ranks_above(rd_data, best_l);
  assign child        = right_better ? rd_data : lreg;
  assign child_idx    = right_better ? ridx : lidx;

  assign stat.full     = full;
  assign stat.empty    = empty;
  assign stat.pos_root = (pos == '0);
  assign stat.one_left = (held_count == CNT_W'(1));
  assign stat.l_out    = (lidx >= n_ext);
  assign stat.up_go    = ranks_above(cur, rd_data);
  assign stat.down_go  = left_better || right_better;

  always_comb begin
    wr_en   = cmd.wr_cur || cmd.up_eval || cmd.down_eval;
    wr_data = cur;
    if (cmd.up_eval && stat.up_go) begin
      wr_data = rd_data;
    end else if (cmd.down_eval && stat.down_go) begin
      wr_data = child;
    end
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RD_PARENT: rd_addr = parent;
      RD_ROOT:   rd_addr = '0;
      RD_LAST:   rd_addr = held_count[ADDR_W-1:0];
      RD_LEFT:   rd_addr = lidx[ADDR_W-1:0];
      RD_RIGHT:  rd_addr = ridx[ADDR_W-1:0];
      default:   rd_addr = '0;
    endcase
  end

  bmhpq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (cmd.load && command == CMD_INSERT && !full) begin
      held_count <= held_count + CNT_W'(1);
    end else if (cmd.cap_root) begin
      held_count <= held_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur.sev <= severity;
      cur.arr <= arrival_stamp;
      cur.tag <= entry_tag;
      res     <= '0;
      pos     <= held_count[ADDR_W-1:0];
      if (command == CMD_INSERT) begin
        res_status <= full ? ST_FULL : ST_OK;
      end else begin
        res_status <= empty ? ST_EMPTY : ST_OK;
      end
    end
    if (cmd.cap_root) begin
      res <= rd_data;
    end
    if (cmd.cap_cur) begin
      cur <= rd_data;
    end
    if (cmd.cap_left) begin
      lreg <= rd_data;
    end
    if (cmd.pos_zero) begin
      pos <= '0;
    end
    if (cmd.up_eval && stat.up_go) begin
      pos <= parent;
    end
    if (cmd.down_eval && stat.down_go) begin
      pos <= child_idx[ADDR_W-1:0];
    end
    if (cmd.fin) begin
      status       <= res_status;
      out_severity <= res.sev;
      out_arrival  <= res.arr;
      out_tag      <= res.tag;
      entry_count  <= count_low8(held_count);
    end
  end

endmodule

@@ src/bmhpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bmhpq_ctrl
// Sequencer for sift-up and sift-down, and the input and output handshakes.
// ----------------------------------------------------------------------------
module bmhpq_ctrl
  import bmhpq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  command,
  output logic  out_valid,
  input  logic  out_ready,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_UP_CHK   = 11'b00000000010,
    S_UP_CMP   = 11'b00000000100,
    S_RD_ROOT  = 11'b00000001000,
    S_ROOT_CAP = 11'b00000010000,
    S_LAST_RD  = 11'b00000100000,
    S_LAST_CAP = 11'b00001000000,
    S_DN_CHK   = 11'b00010000000,
    S_DN_RDR   = 11'b00100000000,
    S_DN_CMP   = 11'b01000000000,
    S_FIN      = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_ROOT;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (command == CMD_INSERT) begin
            state_next = stat.full ? S_FIN : S_UP_CHK;
          end else begin
            state_next = stat.empty ? S_FIN : S_RD_ROOT;
          end
        end
      end
      S_UP_CHK: begin
        if (stat.pos_root) begin
          cmd.wr_cur = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PARENT;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.up_eval = 1'b1;
        state_next  = stat.up_go ? S_UP_CHK : S_FIN;
      end
      S_RD_ROOT: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_ROOT;
        state_next = S_ROOT_CAP;
      end
      S_ROOT_CAP: begin
        cmd.cap_root = 1'b1;
        state_next   = stat.one_left ? S_FIN : S_LAST_RD;
      end
      S_LAST_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_LAST;
        cmd.pos_zero = 1'b1;
        state_next   = S_LAST_CAP;
      end
      S_LAST_CAP: begin
        cmd.cap_cur = 1'b1;
        state_next  = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (stat.l_out) begin
          cmd.wr_cur = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LEFT;
          state_next = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        cmd.cap_left = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_RIGHT;
        state_next   = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.down_eval = 1'b1;
        state_next    = stat.down_go ? S_DN_CHK : S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/binary_max_heap_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_unit
// Binary max-heap priority queue with insert and extract operations.
//
//   Channel  Direction  Handshake              Payload
//   input    in         in_valid / in_ready    command, severity, arrival_stamp,
//                                              entry_tag
//   output   out        out_valid / out_ready  status, out_severity, out_arrival,
//                                              out_tag, entry_count
//
// An insert's result is loaded when its sift-up ends, an extract's when its
// sift-down ends. Each level of a sift goes through the single read port of
// the heap RAM: up, the parent is read, then compared and written; down, the
// left child, then the right child is read, then compared and written.
// One item is processed at a time; a new transfer is taken once the previous
// result has been loaded into the output register, which may still be waiting.
// Reset is synchronous and clears the entry count; the heap RAM is not cleared.
// A stalled output holds the sequencer in its final state until the transfer.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_unit
  import bmhpq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [15:0] severity,
  input  logic [31:0] arrival_stamp,
  input  logic [15:0] entry_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] out_severity,
  output logic [31:0] out_arrival,
  output logic [15:0] out_tag,
  output logic [7:0]  entry_count
);

  cmd_t  cmd;
  stat_t stat;

  bmhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  bmhpq_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .command       (command),
    .severity      (severity),
    .arrival_stamp (arrival_stamp),
    .entry_tag     (entry_tag),
    .status        (status),
    .out_severity  (out_severity),
    .out_arrival   (out_arrival),
    .out_tag       (out_tag),
    .entry_count   (entry_count)
  );

endmodule

@@ src/bmhpq_checker.sv @@
// ----------------------------------------------------------------------------
// bmhpq_checker
// Port-level assertions for the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module bmhpq_checker
  import bmhpq_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [15:0] out_severity,
  input logic [31:0] out_arrival,
  input logic [15:0] out_tag,
  input logic [7:0]  entry_count
);

  localparam logic [7:0] CAP_LOW8 = 8'(CAPACITY);

  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_count))
    else $error("Output changed while stalled.");

  a_busy_after_in : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Input ready while an item is in progress.");

  a_no_entry_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |->
      out_severity == 16'd0 && out_arrival == 32'd0 && out_tag == 16'd0)
    else $error("Entry fields not zero on a failed operation.");

  a_full_count : assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> entry_count == CAP_LOW8)
    else $error("Full drop reported with a wrong count.");

  a_empty_count : assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> entry_count == 8'd0)
    else $error("Empty extract reported with a non-zero count.");

endmodule

bind binary_max_heap_priority_queue_unit bmhpq_checker u_bmhpq_checker (.*);
